>>> sv/lfbr_pkg.sv
`timescale 1ns / 1ps

package lfbr_pkg;

   // panel geometry
   localparam int COLUMNS       = 128;
   localparam int PAGES         = 8;
   localparam int BLANK_COLUMNS = 132;
   localparam int HEADER_STEPS  = 3;

   localparam int ROWS        = PAGES * 8;
   localparam int STORE_BYTES = COLUMNS * PAGES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int STEP_W      = $clog2(HEADER_STEPS + BLANK_COLUMNS);

   // limits in the width of the coordinate ports
   localparam logic [7:0] COLUMNS_B = 8'(COLUMNS);
   localparam logic [7:0] ROWS_B    = 8'(ROWS);

   // job queue between front and back, depth is a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // request command codes
   localparam logic [2:0] CMD_PIXEL   = 3'd0;
   localparam logic [2:0] CMD_BYTE    = 3'd1;
   localparam logic [2:0] CMD_REFRESH = 3'd2;
   localparam logic [2:0] CMD_BLANK   = 3'd3;
   localparam logic [2:0] CMD_TICK    = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_PAGE_CMD_BASE   = 2'd0;
   localparam logic [1:0] CSR_COLUMN_LOW_CMD  = 2'd1;
   localparam logic [1:0] CSR_COLUMN_HIGH_CMD = 2'd2;

   typedef enum logic [2:0] {
      OP_PIXEL   = 3'd0,
      OP_BYTE    = 3'd1,
      OP_REFRESH = 3'd2,
      OP_BLANK   = 3'd3,
      OP_TICK    = 3'd4
   } op_type;

   // one queued job: for a pixel job data is the bit mask
   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
      logic              set;
   } job_type;

   typedef struct packed {
      logic [7:0] page_cmd_base;
      logic [7:0] column_low_cmd;
      logic [7:0] column_high_cmd;
   } cfg_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

>>> sv/lcd_frame_buffer_refresh.sv
`timescale 1ns / 1ps

// Page-organized monochrome LCD frame store with a refresh/blank byte sequencer.
// A request is taken when start is high and busy is low; it goes into a two-word
// job queue and a back end works through the jobs in order over the store
// (one write and one registered read per cycle). Byte writes, refresh starts
// and idle ticks are done in ST_IDLE alone, pixel writes pass through ST_MODIFY
// too (read-modify-write on the store port). A tick that yields a command byte
// or a blank zero byte passes the queue entry and the rsp_ output registers; a
// tick that reads frame data passes the registered store read in ST_EMIT too.
// Results are shown for one cycle with rsp_strobe and cannot be held off, so the
// receiver must take every strobed word. After reset and after each start blank
// the store is cleared one byte a cycle, all 1024 bytes, with busy high throughout.
// Configuration writes are always taken (csr_ready is tied high) and must only
// be made while no request is in flight.
module lcd_frame_buffer_refresh import lfbr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_column,
   input  logic [7:0] req_row,
   input  logic [7:0] req_value,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_data,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   logic [7:0]      page_cmd_base_ff;
   logic [7:0]      column_low_cmd_ff;
   logic [7:0]      column_high_cmd_ff;
   cfg_type         cfg;
   back_status_type status;
   logic            push;
   job_type         push_job;
   logic            pop;
   logic            q_full;
   logic            q_empty;
   job_type         head_job;

   assign csr_ready = 1'b1;

   // command byte registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_cmd_base_ff   <= 8'd176;
         column_low_cmd_ff  <= 8'd16;
         column_high_cmd_ff <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PAGE_CMD_BASE:   page_cmd_base_ff   <= csr_data;
            CSR_COLUMN_LOW_CMD:  column_low_cmd_ff  <= csr_data;
            CSR_COLUMN_HIGH_CMD: column_high_cmd_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign cfg.page_cmd_base   = page_cmd_base_ff;
   assign cfg.column_low_cmd  = column_low_cmd_ff;
   assign cfg.column_high_cmd = column_high_cmd_ff;

   lfbr_front u_front (
      .start      (start),
      .req_cmd    (req_cmd),
      .req_column (req_column),
      .req_row    (req_row),
      .req_value  (req_value),
      .q_full     (q_full),
      .status     (status),
      .busy       (busy),
      .push       (push),
      .push_job   (push_job)
   );

   lfbr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_job (head_job)
   );

   lfbr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .q_empty      (q_empty),
      .head_job     (head_job),
      .pop          (pop),
      .status       (status),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_last     (rsp_last)
   );

endmodule

>>> sv/lfbr_front.sv
`timescale 1ns / 1ps

module lfbr_front import lfbr_pkg::*; (
   input  logic            start,
   input  logic [2:0]      req_cmd,
   input  logic [7:0]      req_column,
   input  logic [7:0]      req_row,
   input  logic [7:0]      req_value,
   input  logic            q_full,
   input  back_status_type status,
   output logic            busy,
   output logic            push,
   output job_type         push_job
);

   logic [7:0]        x;
   logic [7:0]        y;
   logic              pixel_ok;
   logic              byte_ok;
   logic              keep;
   logic [ADDR_W-1:0] pix_addr;
   logic [ADDR_W-1:0] byte_addr;

   // no new word while the queue is full or the store is being cleared
   assign busy = q_full || status.clearing;

   // pixel coordinates are 1-based, byte coordinates 0-based
   assign x        = req_column - 8'd1;
   assign y        = req_row - 8'd1;
   assign pixel_ok = (req_column != 8'd0) && (req_column <= COLUMNS_B) &&
                     (req_row != 8'd0) && (req_row <= ROWS_B);
   assign byte_ok  = (req_column < COLUMNS_B) && (req_row < ROWS_B);

   assign pix_addr  = ADDR_W'(ADDR_W'(y[7:3]) * ADDR_W'(COLUMNS) + ADDR_W'(x));
   assign byte_addr = ADDR_W'(ADDR_W'(req_row[7:3]) * ADDR_W'(COLUMNS) + ADDR_W'(req_column));

   // classify the command, drop out-of-range writes and unknown codes
   always_comb begin
      keep          = 1'b0;
      push_job.op   = OP_TICK;
      push_job.addr = pix_addr;
      push_job.data = 8'(8'd1 << y[2:0]);
      push_job.set  = (req_value != 8'd0);
      case (req_cmd)
         CMD_PIXEL: begin
            keep        = pixel_ok;
            push_job.op = OP_PIXEL;
         end
         CMD_BYTE: begin
            keep          = byte_ok;
            push_job.op   = OP_BYTE;
            push_job.addr = byte_addr;
            push_job.data = req_value;
         end
         CMD_REFRESH: begin
            keep        = 1'b1;
            push_job.op = OP_REFRESH;
         end
         CMD_BLANK: begin
            keep        = 1'b1;
            push_job.op = OP_BLANK;
         end
         CMD_TICK: begin
            keep        = 1'b1;
            push_job.op = OP_TICK;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = start && !busy && keep;

endmodule

>>> sv/lfbr_queue.sv
`timescale 1ns / 1ps

module lfbr_queue import lfbr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head_job
);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;

   assign full     = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> sv/lfbr_back.sv
`timescale 1ns / 1ps

module lfbr_back import lfbr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            q_empty,
   input  job_type         head_job,
   output logic            pop,
   output back_status_type status,
   output logic            rsp_strobe,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_data,
   output logic            rsp_last
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_MODIFY = 4'b0100,
      ST_EMIT   = 4'b1000
   } back_state_type;

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [ADDR_W-1:0] clear_addr_ff;
   logic [ADDR_W-1:0] clear_addr_in;
   logic              seq_active_ff;
   logic              seq_active_in;
   logic              seq_blank_ff;
   logic              seq_blank_in;
   logic [PAGE_W-1:0] page_ff;
   logic [PAGE_W-1:0] page_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [ADDR_W-1:0] hold_addr_ff;
   logic [ADDR_W-1:0] hold_addr_in;
   logic [7:0]        hold_mask_ff;
   logic [7:0]        hold_mask_in;
   logic              hold_set_ff;
   logic              hold_set_in;
   logic              hold_last_ff;
   logic              hold_last_in;
   logic              rsp_strobe_ff;
   logic              rsp_strobe_in;
   logic [7:0]        rsp_byte_ff;
   logic [7:0]        rsp_byte_in;
   logic              rsp_is_data_ff;
   logic              rsp_is_data_in;
   logic              rsp_last_ff;
   logic              rsp_last_in;

   logic [7:0]        mem [STORE_BYTES];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   logic [STEP_W-1:0] last_step;
   logic              at_end;
   logic              page_last;
   logic              seq_done;
   logic [7:0]        header_byte;
   logic [ADDR_W-1:0] data_addr;

   // position in the refresh or blank sequence
   assign last_step = seq_blank_ff ? STEP_W'(HEADER_STEPS + BLANK_COLUMNS - 1)
                                   : STEP_W'(HEADER_STEPS + COLUMNS - 1);
   assign at_end    = (step_ff >= last_step);
   assign page_last = (page_ff == PAGE_W'(PAGES - 1));
   assign seq_done  = at_end && page_last;
   assign data_addr = ADDR_W'(ADDR_W'(page_ff) * ADDR_W'(COLUMNS) +
                              ADDR_W'(step_ff - STEP_W'(HEADER_STEPS)));

   // page select, column low and column high commands
   always_comb begin
      if (step_ff == STEP_W'(0)) begin
         header_byte = cfg.page_cmd_base | 8'(page_ff);
      end else if (step_ff == STEP_W'(1)) begin
         header_byte = cfg.column_low_cmd;
      end else begin
         header_byte = cfg.column_high_cmd;
      end
   end

   // job execution
   always_comb begin
      state_in       = state_ff;
      clear_addr_in  = clear_addr_ff;
      seq_active_in  = seq_active_ff;
      seq_blank_in   = seq_blank_ff;
      page_in        = page_ff;
      step_in        = step_ff;
      hold_addr_in   = hold_addr_ff;
      hold_mask_in   = hold_mask_ff;
      hold_set_in    = hold_set_ff;
      hold_last_in   = hold_last_ff;
      rsp_strobe_in  = 1'b0;
      rsp_byte_in    = rsp_byte_ff;
      rsp_is_data_in = rsp_is_data_ff;
      rsp_last_in    = rsp_last_ff;
      pop            = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = head_job.addr;
      mem_wdata      = head_job.data;
      mem_re         = 1'b0;
      mem_raddr      = head_job.addr;
      case (state_ff)
         ST_CLEAR: begin
            mem_we        = 1'b1;
            mem_waddr     = clear_addr_ff;
            mem_wdata     = 8'd0;
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == ADDR_W'(STORE_BYTES - 1)) begin
               clear_addr_in = '0;
               state_in      = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               case (head_job.op)
                  OP_PIXEL: begin
                     mem_re       = 1'b1;
                     hold_addr_in = head_job.addr;
                     hold_mask_in = head_job.data;
                     hold_set_in  = head_job.set;
                     state_in     = ST_MODIFY;
                  end
                  OP_BYTE: begin
                     mem_we = 1'b1;
                  end
                  OP_REFRESH: begin
                     seq_active_in = 1'b1;
                     seq_blank_in  = 1'b0;
                     page_in       = '0;
                     step_in       = '0;
                  end
                  OP_BLANK: begin
                     seq_active_in = 1'b1;
                     seq_blank_in  = 1'b1;
                     page_in       = '0;
                     step_in       = '0;
                     clear_addr_in = '0;
                     state_in      = ST_CLEAR;
                  end
                  OP_TICK: begin
                     if (seq_active_ff) begin
                        // advance to the next byte of the sequence
                        if (at_end) begin
                           step_in = '0;
                           if (page_last) begin
                              seq_active_in = 1'b0;
                              page_in       = '0;
                           end else begin
                              page_in = page_ff + PAGE_W'(1);
                           end
                        end else begin
                           step_in = step_ff + STEP_W'(1);
                        end
                        if (step_ff < STEP_W'(HEADER_STEPS)) begin
                           rsp_strobe_in  = 1'b1;
                           rsp_byte_in    = header_byte;
                           rsp_is_data_in = 1'b0;
                           rsp_last_in    = seq_done;
                        end else if (seq_blank_ff) begin
                           rsp_strobe_in  = 1'b1;
                           rsp_byte_in    = 8'd0;
                           rsp_is_data_in = 1'b1;
                           rsp_last_in    = seq_done;
                        end else begin
                           mem_re       = 1'b1;
                           mem_raddr    = data_addr;
                           hold_last_in = seq_done;
                           state_in     = ST_EMIT;
                        end
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_MODIFY: begin
            // second half of the pixel read-modify-write
            mem_we    = 1'b1;
            mem_waddr = hold_addr_ff;
            mem_wdata = hold_set_ff ? (rd_data_ff | hold_mask_ff)
                                    : (rd_data_ff & ~hold_mask_ff);
            state_in  = ST_IDLE;
         end
         ST_EMIT: begin
            rsp_strobe_in  = 1'b1;
            rsp_byte_in    = rd_data_ff;
            rsp_is_data_in = 1'b1;
            rsp_last_in    = hold_last_ff;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         seq_active_ff <= 1'b0;
         seq_blank_ff  <= 1'b0;
         page_ff       <= '0;
         step_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         seq_active_ff <= seq_active_in;
         seq_blank_ff  <= seq_blank_in;
         page_ff       <= page_in;
         step_ff       <= step_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // held job fields and result word
   always_ff @(posedge clock) begin
      hold_addr_ff   <= hold_addr_in;
      hold_mask_ff   <= hold_mask_in;
      hold_set_ff    <= hold_set_in;
      hold_last_ff   <= hold_last_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_is_data_ff <= rsp_is_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // frame store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_is_data     = rsp_is_data_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> sv/lfbr_checker.sv
`timescale 1ns / 1ps

module lfbr_checker import lfbr_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [2:0] req_cmd,
   input logic       rsp_strobe,
   input logic       rsp_is_data,
   input logic       rsp_last
);

   // the store is cleared right after reset, so no request is taken then
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> busy)
      else $error("busy low right after reset");

   // a sequence always ends on a data byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> rsp_is_data)
      else $error("last marker on a command byte");

   // the word after a finished sequence cannot be a data byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !(rsp_strobe && rsp_is_data))
      else $error("data byte right after end of sequence");

   // a taken blank request stalls the input, for the store clear
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_BLANK) |-> ##[1:4] busy)
      else $error("no stall after a blank request");

endmodule

bind lcd_frame_buffer_refresh lfbr_checker u_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lfbr_pkg::*;

   // codes the block must ignore
   localparam logic [2:0] CMD_UNKNOWN_MIN = CMD_TICK + 3'd1;
   localparam logic [2:0] CMD_UNKNOWN_MAX = 3'd7;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       last;
   } panel_word_type;

   // one row of the opening stimulus table
   typedef struct {
      logic [2:0]     cmd;
      logic [7:0]     col;
      logic [7:0]     row;
      logic [7:0]     val;
      bit             typed;
      bit             emits;
      panel_word_type word;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_cmd;
   logic [7:0] req_column;
   logic [7:0] req_row;
   logic [7:0] req_value;
   logic       rsp_strobe;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_data;
   logic       rsp_last;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [7:0] csr_data;

   // predictor copy of the frame store, sequencer and registers
   logic [7:0]        panel_store [STORE_BYTES];
   logic              seq_on;
   logic              seq_blank;
   logic [PAGE_W-1:0] seq_page;
   logic [7:0]        seq_step;
   logic [7:0]        cfg_page_base;
   logic [7:0]        cfg_col_low;
   logic [7:0]        cfg_col_high;

   panel_word_type panel_words_due[$];
   stim_row_type   opening_rows[$];
   int             mismatch_count = 0;
   int             words_checked  = 0;
   int             burst_left     = 0;

   lcd_frame_buffer_refresh i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_column   (req_column),
      .req_row      (req_row),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      if (mismatch_count < 50) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   // next panel word for one request, updates the predicted state
   function automatic void predict_panel_step(input logic [2:0] c, input logic [7:0] x,
                                              input logic [7:0] y, input logic [7:0] v,
                                              output bit emits, output panel_word_type w);
      int         pos;
      int         ncols;
      logic [7:0] mask;
      emits = 1'b0;
      w     = '0;
      case (c)
         CMD_PIXEL: begin
            // 1-based coordinates, zero is off the panel
            if (x >= 1 && x <= COLUMNS && y >= 1 && y <= ROWS) begin
               pos  = (int'(x) - 1) + ((int'(y) - 1) / 8) * COLUMNS;
               mask = 8'(1) << ((int'(y) - 1) % 8);
               if (v != 8'd0) panel_store[pos] = panel_store[pos] | mask;
               else panel_store[pos] = panel_store[pos] & ~mask;
            end
         end
         CMD_BYTE: begin
            if (x < COLUMNS && y < ROWS) begin
               panel_store[int'(x) + (int'(y) / 8) * COLUMNS] = v;
            end
         end
         CMD_REFRESH: begin
            seq_on    = 1'b1;
            seq_blank = 1'b0;
            seq_page  = '0;
            seq_step  = '0;
         end
         CMD_BLANK: begin
            foreach (panel_store[i]) panel_store[i] = 8'd0;
            seq_on    = 1'b1;
            seq_blank = 1'b1;
            seq_page  = '0;
            seq_step  = '0;
         end
         CMD_TICK: begin
            if (seq_on) begin
               emits = 1'b1;
               ncols = seq_blank ? BLANK_COLUMNS : COLUMNS;
               // page header first, then the data run
               if (seq_step == 8'd0) w.out_byte = cfg_page_base | 8'(seq_page);
               else if (seq_step == 8'd1) w.out_byte = cfg_col_low;
               else if (seq_step == 8'd2) w.out_byte = cfg_col_high;
               else begin
                  w.is_data  = 1'b1;
                  w.out_byte = seq_blank ? 8'h00 :
                     panel_store[int'(seq_page) * COLUMNS + int'(seq_step) - HEADER_STEPS];
               end
               if (int'(seq_step) >= HEADER_STEPS + ncols - 1) begin
                  seq_step = '0;
                  if (int'(seq_page) + 1 >= PAGES) begin
                     w.last   = 1'b1;
                     seq_on   = 1'b0;
                     seq_page = '0;
                  end else begin
                     seq_page = seq_page + PAGE_W'(1);
                  end
               end else begin
                  seq_step = seq_step + 8'd1;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // one request word, sent in bursts with random gaps
   task automatic send_request(input logic [2:0] c, input logic [7:0] x, input logic [7:0] y,
                               input logic [7:0] v, input bit typed, input bit typed_emits,
                               input panel_word_type typed_word);
      bit             emits;
      panel_word_type w;
      int             gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start      <= 1'b1;
      req_cmd    <= c;
      req_column <= x;
      req_row    <= y;
      req_value  <= v;
      do @(posedge clock); while (busy);
      predict_panel_step(c, x, y, v, emits, w);
      if (typed) begin
         emits = typed_emits;
         w     = typed_word;
      end
      if (emits) panel_words_due.push_back(w);
   endtask

   // random request; writes lean toward the page being sent
   task automatic pick_request(input int tick_pct, input int start_pct, output logic [2:0] c,
                               output logic [7:0] x, output logic [7:0] y,
                               output logic [7:0] v);
      int r;
      int sel;
      bit aim;
      r   = $urandom_range(0, 99);
      sel = $urandom_range(0, 19);
      aim = ($urandom_range(0, 9) < 7);
      x   = 8'($urandom_range(0, 255));
      y   = 8'($urandom_range(0, 255));
      v   = 8'($urandom_range(0, 255));
      if (r < tick_pct) begin
         c = CMD_TICK;
      end else if (r < tick_pct + start_pct) begin
         c = ($urandom_range(0, 4) == 0) ? CMD_BLANK : CMD_REFRESH;
      end else if (sel < 2) begin
         c = 3'($urandom_range(CMD_UNKNOWN_MIN, CMD_UNKNOWN_MAX));
      end else if (sel < 4) begin
         // full-range coordinates, mostly off the panel
         c = sel[0] ? CMD_BYTE : CMD_PIXEL;
      end else if (sel[0]) begin
         c = CMD_PIXEL;
         x = 8'($urandom_range(1, COLUMNS));
         y = aim ? 8'(int'(seq_page) * 8 + $urandom_range(1, 8)) : 8'($urandom_range(1, ROWS));
         if ($urandom_range(0, 1) == 0) v = 8'd0;
      end else begin
         c = CMD_BYTE;
         x = 8'($urandom_range(0, COLUMNS - 1));
         y = aim ? 8'(int'(seq_page) * 8 + $urandom_range(0, 7)) :
                   8'($urandom_range(0, ROWS - 1));
      end
   endtask

   // refresh or blank sequence with writes and noise mixed in, up to max_items words
   task automatic run_sequence(input bit blank, input int tick_pct, input int max_items);
      logic [2:0] c;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] v;
      int         n;
      send_request(blank ? CMD_BLANK : CMD_REFRESH, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      n = 1;
      while (seq_on && n < max_items) begin
         pick_request(tick_pct, 0, c, x, y, v);
         send_request(c, x, y, v, 1'b0, 1'b0, '0);
         n++;
      end
   endtask

   // wait until no request is in flight
   task automatic settle_block();
      start <= 1'b0;
      while (panel_words_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write the three panel command registers
   task automatic load_panel_cmds(input logic [7:0] page_base, input logic [7:0] col_low,
                                  input logic [7:0] col_high);
      logic [1:0] idx [3];
      logic [7:0] dat [3];
      idx = '{CSR_PAGE_CMD_BASE, CSR_COLUMN_LOW_CMD, CSR_COLUMN_HIGH_CMD};
      dat = '{page_base, col_low, col_high};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= dat[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_PAGE_CMD_BASE:   cfg_page_base = dat[i];
            CSR_COLUMN_LOW_CMD:  cfg_col_low   = dat[i];
            CSR_COLUMN_HIGH_CMD: cfg_col_high  = dat[i];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   function automatic void add_row(input logic [2:0] c, input logic [7:0] x,
                                   input logic [7:0] y, input logic [7:0] v, input bit typed,
                                   input bit emits, input logic [7:0] b, input logic d,
                                   input logic l);
      stim_row_type r;
      r.cmd   = c;
      r.col   = x;
      r.row   = y;
      r.val   = v;
      r.typed = typed;
      r.emits = emits;
      r.word  = '{out_byte: b, is_data: d, last: l};
      opening_rows.push_back(r);
   endfunction

   // word checker, the receiver takes every strobed word
   always @(posedge clock) begin : word_check
      panel_word_type due;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (panel_words_due.size() == 0) begin
            flag_mismatch($sformatf("word 0x%02h with nothing expected", rsp_out_byte));
         end else begin
            due = panel_words_due.pop_front();
            if (rsp_out_byte !== due.out_byte)
               flag_mismatch($sformatf("word %0d out_byte 0x%02h, want 0x%02h",
                                       words_checked, rsp_out_byte, due.out_byte));
            if (rsp_is_data !== due.is_data)
               flag_mismatch($sformatf("word %0d is_data %b, want %b",
                                       words_checked, rsp_is_data, due.is_data));
            if (rsp_last !== due.last)
               flag_mismatch($sformatf("word %0d last %b, want %b",
                                       words_checked, rsp_last, due.last));
         end
         words_checked++;
      end
   end

   initial begin
      logic [2:0] c;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] v;
      int         k;

      reset      <= 1'b1;
      start      <= 1'b0;
      req_cmd    <= CMD_PIXEL;
      req_column <= 8'd0;
      req_row    <= 8'd0;
      req_value  <= 8'd0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_PAGE_CMD_BASE;
      csr_data   <= 8'd0;

      foreach (panel_store[i]) panel_store[i] = 8'd0;
      seq_on        = 1'b0;
      seq_blank     = 1'b0;
      seq_page      = '0;
      seq_step      = '0;
      cfg_page_base = 8'd176;
      cfg_col_low   = 8'd16;
      cfg_col_high  = 8'd0;

      // opening table: idle tick, edges of the coordinates, ignored codes, short runs
      add_row(CMD_TICK,    8'd0,   8'd0,   8'd0,   1, 0, 8'h00, 0, 0);
      add_row(CMD_PIXEL,   8'd1,   8'd1,   8'd1,   1, 0, 8'h00, 0, 0);
      add_row(CMD_PIXEL,   8'd128, 8'd64,  8'hFF,  1, 0, 8'h00, 0, 0);
      add_row(CMD_PIXEL,   8'd0,   8'd5,   8'd1,   1, 0, 8'h00, 0, 0);
      add_row(CMD_PIXEL,   8'd5,   8'd0,   8'd1,   1, 0, 8'h00, 0, 0);
      add_row(CMD_PIXEL,   8'd129, 8'd64,  8'd1,   1, 0, 8'h00, 0, 0);
      add_row(CMD_PIXEL,   8'd128, 8'd65,  8'd1,   1, 0, 8'h00, 0, 0);
      add_row(CMD_PIXEL,   8'd255, 8'd255, 8'hFF,  1, 0, 8'h00, 0, 0);
      add_row(CMD_BYTE,    8'd0,   8'd0,   8'hA4,  1, 0, 8'h00, 0, 0);
      add_row(CMD_BYTE,    8'd128, 8'd0,   8'hFF,  1, 0, 8'h00, 0, 0);
      add_row(CMD_BYTE,    8'd0,   8'd64,  8'hFF,  1, 0, 8'h00, 0, 0);
      add_row(CMD_BYTE,    8'd255, 8'd255, 8'hFF,  1, 0, 8'h00, 0, 0);
      add_row(CMD_PIXEL,   8'd3,   8'd9,   8'd1,   1, 0, 8'h00, 0, 0);
      add_row(CMD_PIXEL,   8'd3,   8'd9,   8'd0,   1, 0, 8'h00, 0, 0);
      add_row(CMD_UNKNOWN_MAX, 8'hFF, 8'hFF, 8'hFF, 1, 0, 8'h00, 0, 0);
      add_row(CMD_REFRESH, 8'd0,   8'd0,   8'd0,   1, 0, 8'h00, 0, 0);
      add_row(CMD_TICK,    8'd0,   8'd0,   8'd0,   1, 1, 8'hB0, 0, 0);
      add_row(CMD_TICK,    8'd0,   8'd0,   8'd0,   1, 1, 8'h10, 0, 0);
      add_row(CMD_TICK,    8'd0,   8'd0,   8'd0,   1, 1, 8'h00, 0, 0);
      // write lands in a byte that a later tick sends
      add_row(CMD_BYTE,    8'd1,   8'd0,   8'h81,  1, 0, 8'h00, 0, 0);
      add_row(CMD_TICK,    8'd0,   8'd0,   8'd0,   0, 0, 8'h00, 0, 0);
      add_row(CMD_TICK,    8'd0,   8'd0,   8'd0,   0, 0, 8'h00, 0, 0);
      add_row(CMD_BLANK,   8'd0,   8'd0,   8'd0,   1, 0, 8'h00, 0, 0);
      add_row(CMD_TICK,    8'd0,   8'd0,   8'd0,   1, 1, 8'hB0, 0, 0);
      add_row(CMD_TICK,    8'd0,   8'd0,   8'd0,   1, 1, 8'h10, 0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i]) begin
         send_request(opening_rows[i].cmd, opening_rows[i].col, opening_rows[i].row,
                      opening_rows[i].val, opening_rows[i].typed, opening_rows[i].emits,
                      opening_rows[i].word);
      end

      // full refresh with writes chasing the page being sent
      settle_block();
      load_panel_cmds(8'h00, 8'hFF, 8'h00);
      run_sequence(1'b0, 88, 1400);

      // first pages of a blank with the opposite register extremes
      settle_block();
      load_panel_cmds(8'hFF, 8'h00, 8'hFF);
      run_sequence(1'b1, 95, 500);

      // random registers, restarts and broken sequences
      settle_block();
      load_panel_cmds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
      repeat (120) begin
         pick_request(50, 6, c, x, y, v);
         send_request(c, x, y, v, 1'b0, 1'b0, '0);
      end

      // drain
      start <= 1'b0;
      for (k = 0; k < 4000 && panel_words_due.size() != 0; k++) @(posedge clock);
      repeat (20) @(posedge clock);
      while (panel_words_due.size() != 0) begin
         void'(panel_words_due.pop_front());
         flag_mismatch("expected word never arrived");
      end

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
